// ----- rtl/aarm_pkg.sv -----
// Shared constants for the axis-angle rotation matrix pipeline.
`default_nettype none

package aarm_pkg;

	// Default and supported CORDIC depth.
	localparam int CORDIC_STAGES_DEF = 24;
	localparam int CORDIC_MAX        = 32;

	// Stages of the axis path: squares, sum, shift search, shift,
	// 31 root steps, 33 quotient steps, multiply, round.
	localparam int SQRT_STEPS = 31;
	localparam int DIV_STEPS  = 33;
	localparam int AXIS_LAT   = 4 + SQRT_STEPS + DIV_STEPS + 2;

	// Angle path stages around the CORDIC: reduce, fold, sign fix.
	localparam int ANG_LAT_EXTRA = 3;

	// Matrix product and sum stages.
	localparam int MAT_LAT = 4;

	// round(atan(2^-i) * 2^30)
	localparam logic [31:0] ATAN_Q30 [CORDIC_MAX] = '{
		32'd843314857, 32'd497837829, 32'd263043837, 32'd133525159,
		32'd67021687,  32'd33543516,  32'd16775851,  32'd8388437,
		32'd4194283,   32'd2097149,   32'd1048576,   32'd524288,
		32'd262144,    32'd131072,    32'd65536,     32'd32768,
		32'd16384,     32'd8192,      32'd4096,      32'd2048,
		32'd1024,      32'd512,       32'd256,       32'd128,
		32'd64,        32'd32,        32'd16,        32'd8,
		32'd4,         32'd2,         32'd1,         32'd0
	};

endpackage

`default_nettype wire

// ----- rtl/aarm_angle.sv -----
// Angle reduction and pipelined CORDIC giving cosine and sine in Q1.30.
`default_nettype none

module aarm_angle #(
	parameter int CORDIC_STAGES = aarm_pkg::CORDIC_STAGES_DEF
) (
	input  logic               clk,
	input  logic               en,
	input  logic signed [31:0] angle,
	output logic signed [31:0] cos_v,
	output logic signed [31:0] sin_v
);

	localparam logic signed [33:0] TWO_PI_Q27  = 34'sd843314857;
	localparam logic signed [33:0] PI_Q27      = 34'sd421657428;
	localparam logic signed [33:0] PI_Q30      = 34'sd3373259426;
	localparam logic signed [33:0] HALF_PI_Q30 = 34'sd1686629713;
	localparam logic signed [33:0] GAIN_Q30    = 34'sd652032874;
	// k * 2pi for k = -3 .. 2, the only quotients a Q4.27 angle can have
	localparam logic signed [33:0] K_TWO_PI [6] = '{
		-34'sd2529944571, -34'sd1686629714, -34'sd843314857,
		34'sd0, 34'sd843314857, 34'sd1686629714
	};

	logic signed [33:0] ang_ext;
	logic signed [33:0] cand [6];
	logic signed [33:0] r_mod;
	logic signed [33:0] r_s1;
	logic signed [33:0] r_wrap;
	logic signed [33:0] z_w;
	logic signed [33:0] z_fold;
	logic               neg_fold;
	logic signed [33:0] z_s2;
	logic               neg_s2;

	logic signed [33:0] x_sc [CORDIC_STAGES];
	logic signed [33:0] y_sc [CORDIC_STAGES];
	logic signed [33:0] z_sc [CORDIC_STAGES];
	logic               n_sc [CORDIC_STAGES];

	logic signed [33:0] x_neg;
	logic signed [33:0] y_neg;

	// floor modulo 2pi: exactly one candidate lands in [0, 2pi)
	always_comb begin
		ang_ext = 34'(angle);
		r_mod   = '0;
		for (int k = 0; k < 6; k++) begin
			cand[k] = ang_ext - K_TWO_PI[k];
			if (cand[k] >= 0 && cand[k] < TWO_PI_Q27)
				r_mod = cand[k];
		end
	end

	always_ff @(posedge clk) begin
		if (en)
			r_s1 <= r_mod;
	end

	// wrap to [-pi, pi), go to Q.30, fold into [-pi/2, pi/2]
	always_comb begin
		r_wrap   = (r_s1 >= PI_Q27) ? r_s1 - TWO_PI_Q27 : r_s1;
		z_w      = r_wrap <<< 3;
		z_fold   = z_w;
		neg_fold = 1'b0;
		if (z_w > HALF_PI_Q30) begin
			z_fold   = z_w - PI_Q30;
			neg_fold = 1'b1;
		end else if (z_w < -HALF_PI_Q30) begin
			z_fold   = z_w + PI_Q30;
			neg_fold = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			z_s2   <= z_fold;
			neg_s2 <= neg_fold;
		end
	end

	for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cord
		logic signed [33:0] xi;
		logic signed [33:0] yi;
		logic signed [33:0] zi;
		logic               ni;
		logic signed [33:0] at;

		if (i == 0) begin : g_first
			assign xi = GAIN_Q30;
			assign yi = '0;
			assign zi = z_s2;
			assign ni = neg_s2;
		end else begin : g_next
			assign xi = x_sc[i-1];
			assign yi = y_sc[i-1];
			assign zi = z_sc[i-1];
			assign ni = n_sc[i-1];
		end

		assign at = $signed({2'b00, aarm_pkg::ATAN_Q30[i]});

		always_ff @(posedge clk) begin
			if (en) begin
				n_sc[i] <= ni;
				if (zi >= 0) begin
					x_sc[i] <= xi - (yi >>> i);
					y_sc[i] <= yi + (xi >>> i);
					z_sc[i] <= zi - at;
				end else begin
					x_sc[i] <= xi + (yi >>> i);
					y_sc[i] <= yi - (xi >>> i);
					z_sc[i] <= zi + at;
				end
			end
		end
	end

	assign x_neg = -x_sc[CORDIC_STAGES-1];
	assign y_neg = -y_sc[CORDIC_STAGES-1];

	always_ff @(posedge clk) begin
		if (en) begin
			cos_v <= n_sc[CORDIC_STAGES-1] ? x_neg[31:0] : x_sc[CORDIC_STAGES-1][31:0];
			sin_v <= n_sc[CORDIC_STAGES-1] ? y_neg[31:0] : y_sc[CORDIC_STAGES-1][31:0];
		end
	end

endmodule

`default_nettype wire

// ----- rtl/aarm_axis.sv -----
// Axis normalization: sum of squares, even shift, root and reciprocal steps.
`default_nettype none

module aarm_axis (
	input  logic               clk,
	input  logic               en,
	input  logic signed [23:0] axis_x,
	input  logic signed [23:0] axis_y,
	input  logic signed [23:0] axis_z,
	output logic signed [31:0] u_x,
	output logic signed [31:0] u_y,
	output logic signed [31:0] u_z,
	output logic               zero_v
);

	localparam int SQ = aarm_pkg::SQRT_STEPS;
	localparam int DV = aarm_pkg::DIV_STEPS;

	typedef struct packed {
		logic signed [31:0] sx;
		logic signed [31:0] sy;
		logic signed [31:0] sz;
		logic               zero;
	} side_t;

	logic signed [23:0] a_in [3];
	logic signed [47:0] pr [3];
	logic        [46:0] sq_s1 [3];
	logic signed [23:0] a_s1 [3];
	logic               zero_s1;
	logic        [47:0] sum_s2;
	logic signed [23:0] a_s2 [3];
	logic               zero_s2;
	logic        [5:0]  msb;
	logic        [6:0]  h_full;
	logic        [47:0] sum_s3;
	logic        [4:0]  h_s3;
	logic signed [23:0] a_s3 [3];
	logic               zero_s3;
	logic        [61:0] v_s4;
	side_t              side_s4;

	logic        [61:0] rem_sq [SQ];
	logic        [61:0] res_sq [SQ];
	side_t              side_sq [SQ];

	logic        [32:0] rem_dv [DV];
	logic        [32:0] q_dv [DV];
	logic        [31:0] n_dv [DV];
	side_t              side_dv [DV];

	logic signed [65:0] pu [3];
	logic signed [65:0] pu_s1 [3];
	logic               zero_u1;
	logic signed [65:0] ur [3];

	assign a_in[0] = axis_x;
	assign a_in[1] = axis_y;
	assign a_in[2] = axis_z;

	always_comb begin
		for (int k = 0; k < 3; k++)
			pr[k] = a_in[k] * a_in[k];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				sq_s1[k] <= pr[k][46:0];
				a_s1[k]  <= a_in[k];
			end
			zero_s1 <= (axis_x == '0) && (axis_y == '0) && (axis_z == '0);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s2  <= 48'(sq_s1[0]) + 48'(sq_s1[1]) + 48'(sq_s1[2]);
			a_s2    <= a_s1;
			zero_s2 <= zero_s1;
		end
	end

	// half of the smallest even shift that lifts the sum to 2^60
	always_comb begin
		msb = '0;
		for (int b = 0; b < 48; b++)
			if (sum_s2[b])
				msb = 6'(b);
		h_full = (7'd61 - 7'(msb)) >> 1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s3  <= sum_s2;
			h_s3    <= h_full[4:0];
			a_s3    <= a_s2;
			zero_s3 <= zero_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			v_s4         <= 62'(sum_s3) << {h_s3, 1'b0};
			side_s4.sx   <= 32'(a_s3[0]) <<< h_s3;
			side_s4.sy   <= 32'(a_s3[1]) <<< h_s3;
			side_s4.sz   <= 32'(a_s3[2]) <<< h_s3;
			side_s4.zero <= zero_s3;
		end
	end

	// integer square root, one result bit per stage
	for (genvar j = 0; j < SQ; j++) begin : g_sqrt
		logic [61:0] remi;
		logic [61:0] resi;
		side_t       sdi;
		logic [61:0] bit_v;
		logic [62:0] rb;

		if (j == 0) begin : g_first
			assign remi = v_s4;
			assign resi = '0;
			assign sdi  = side_s4;
		end else begin : g_next
			assign remi = rem_sq[j-1];
			assign resi = res_sq[j-1];
			assign sdi  = side_sq[j-1];
		end

		assign bit_v = 62'(1) << (60 - 2 * j);
		assign rb    = {1'b0, resi} + {1'b0, bit_v};

		always_ff @(posedge clk) begin
			if (en) begin
				side_sq[j] <= sdi;
				if ({1'b0, remi} >= rb) begin
					rem_sq[j] <= remi - rb[61:0];
					res_sq[j] <= (resi >> 1) + bit_v;
				end else begin
					rem_sq[j] <= remi;
					res_sq[j] <= resi >> 1;
				end
			end
		end
	end

	// 2^62 / n, one quotient bit per stage
	for (genvar d = 0; d < DV; d++) begin : g_div
		logic [32:0] remi;
		logic [32:0] qi;
		logic [31:0] ni;
		side_t       sdi;
		logic [32:0] rs;

		if (d == 0) begin : g_first
			assign remi = 33'd536870912;
			assign qi   = '0;
			assign ni   = res_sq[SQ-1][31:0];
			assign sdi  = side_sq[SQ-1];
		end else begin : g_next
			assign remi = rem_dv[d-1];
			assign qi   = q_dv[d-1];
			assign ni   = n_dv[d-1];
			assign sdi  = side_dv[d-1];
		end

		assign rs = {remi[31:0], 1'b0};

		always_ff @(posedge clk) begin
			if (en) begin
				n_dv[d]    <= ni;
				side_dv[d] <= sdi;
				if (rs >= {1'b0, ni}) begin
					rem_dv[d] <= rs - {1'b0, ni};
					q_dv[d]   <= {qi[31:0], 1'b1};
				end else begin
					rem_dv[d] <= rs;
					q_dv[d]   <= {qi[31:0], 1'b0};
				end
			end
		end
	end

	always_comb begin
		pu[0] = side_dv[DV-1].sx * $signed({1'b0, q_dv[DV-1]});
		pu[1] = side_dv[DV-1].sy * $signed({1'b0, q_dv[DV-1]});
		pu[2] = side_dv[DV-1].sz * $signed({1'b0, q_dv[DV-1]});
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pu_s1   <= pu;
			zero_u1 <= side_dv[DV-1].zero;
		end
	end

	always_comb begin
		for (int k = 0; k < 3; k++)
			ur[k] = (pu_s1[k] + 66'sd2147483648) >>> 32;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			u_x    <= ur[0][31:0];
			u_y    <= ur[1][31:0];
			u_z    <= ur[2][31:0];
			zero_v <= zero_u1;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/aarm_matrix.sv -----
// Rodrigues products, sums and saturation for the nine matrix entries.
`default_nettype none

module aarm_matrix (
	input  logic               clk,
	input  logic               en,
	input  logic signed [31:0] u_x,
	input  logic signed [31:0] u_y,
	input  logic signed [31:0] u_z,
	input  logic signed [31:0] cos_v,
	input  logic signed [31:0] sin_v,
	input  logic               zero_v,
	output logic signed [31:0] m_out [9],
	output logic               zero_out
);

	// pairs 00 01 02 11 12 22
	localparam int PI_I [6] = '{0, 0, 0, 1, 1, 2};
	localparam int PI_J [6] = '{0, 1, 2, 1, 2, 2};

	logic signed [31:0] u [3];
	logic signed [63:0] pu_s1 [6];
	logic signed [63:0] ps_s1 [3];
	logic signed [32:0] t_s1;
	logic signed [31:0] c_s1;
	logic               zero_s1;

	logic signed [63:0] qu_w [6];
	logic signed [63:0] qs_w [3];
	logic signed [33:0] qu_s2 [6];
	logic signed [33:0] qs_s2 [3];
	logic signed [32:0] t_s2;
	logic signed [31:0] c_s2;
	logic               zero_s2;

	logic signed [66:0] pt_s3 [6];
	logic signed [33:0] qs_s3 [3];
	logic signed [31:0] c_s3;
	logic               zero_s3;

	logic signed [66:0] qq_w [6];
	logic signed [37:0] qq [6];
	logic signed [37:0] cc;
	logic signed [37:0] qs [3];
	logic signed [37:0] m_w [9];

	function automatic logic signed [31:0] sat32(input logic signed [37:0] v);
		if (v > 38'sd2147483647)
			return 32'sh7fffffff;
		else if (v < -38'sd2147483648)
			return 32'sh80000000;
		else
			return v[31:0];
	endfunction

	assign u[0] = u_x;
	assign u[1] = u_y;
	assign u[2] = u_z;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int p = 0; p < 6; p++)
				pu_s1[p] <= 64'(u[PI_I[p]]) * 64'(u[PI_J[p]]);
			for (int k = 0; k < 3; k++)
				ps_s1[k] <= 64'(u[k]) * 64'(sin_v);
			t_s1    <= 33'sd1073741824 - 33'(cos_v);
			c_s1    <= cos_v;
			zero_s1 <= zero_v;
		end
	end

	always_comb begin
		for (int p = 0; p < 6; p++)
			qu_w[p] = (pu_s1[p] + 64'sd536870912) >>> 30;
		for (int k = 0; k < 3; k++)
			qs_w[k] = (ps_s1[k] + 64'sd536870912) >>> 30;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int p = 0; p < 6; p++)
				qu_s2[p] <= qu_w[p][33:0];
			for (int k = 0; k < 3; k++)
				qs_s2[k] <= qs_w[k][33:0];
			t_s2    <= t_s1;
			c_s2    <= c_s1;
			zero_s2 <= zero_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int p = 0; p < 6; p++)
				pt_s3[p] <= 67'(qu_s2[p]) * 67'(t_s2);
			qs_s3   <= qs_s2;
			c_s3    <= c_s2;
			zero_s3 <= zero_s2;
		end
	end

	always_comb begin
		for (int p = 0; p < 6; p++) begin
			qq_w[p] = (pt_s3[p] + 67'sd536870912) >>> 30;
			qq[p]   = qq_w[p][37:0];
		end
		for (int k = 0; k < 3; k++)
			qs[k] = 38'(qs_s3[k]);
		cc     = 38'(c_s3);
		m_w[0] = cc + qq[0];
		m_w[1] = qq[1] - qs[2];
		m_w[2] = qq[2] + qs[1];
		m_w[3] = qq[1] + qs[2];
		m_w[4] = cc + qq[3];
		m_w[5] = qq[4] - qs[0];
		m_w[6] = qq[2] - qs[1];
		m_w[7] = qq[4] + qs[0];
		m_w[8] = cc + qq[5];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 9; k++)
				m_out[k] <= zero_s3 ? '0 : sat32(m_w[k]);
			zero_out <= zero_s3;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/axis_angle_rotation_matrix.sv -----
// Top level: axis-angle to 3x3 rotation matrix, fully pipelined.
`default_nettype none

// Turns an angle (Q4.27 radians, any 32-bit value) and an integer axis
// vector into the Rodrigues rotation matrix, nine Q1.30 entries in
// row-major order, saturated to 32 bits. A zero axis gives a zero matrix
// with zero_axis set. The block takes one word per cycle while the output
// is not stalled; its depth is set by the axis path (four setup stages, 31
// square-root steps, 33 reciprocal quotient steps, two scaling stages)
// plus four matrix stages. The angle path (reduction, fold, CORDIC_STAGES
// CORDIC stages, sign fix) is shorter and is delayed to meet the axis path.
// The whole pipeline advances together whenever the output register is
// empty or being drained, so in_ready depends on out_ready and the
// output valid only. Nothing is lost or repeated under stalls.
module axis_angle_rotation_matrix #(
	parameter int CORDIC_STAGES = aarm_pkg::CORDIC_STAGES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [31:0] angle,
	input  logic signed [23:0] axis_x,
	input  logic signed [23:0] axis_y,
	input  logic signed [23:0] axis_z,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] entry_00,
	output logic signed [31:0] entry_01,
	output logic signed [31:0] entry_02,
	output logic signed [31:0] entry_10,
	output logic signed [31:0] entry_11,
	output logic signed [31:0] entry_12,
	output logic signed [31:0] entry_20,
	output logic signed [31:0] entry_21,
	output logic signed [31:0] entry_22,
	output logic               zero_axis
);

	localparam int ANG_LAT = CORDIC_STAGES + aarm_pkg::ANG_LAT_EXTRA;
	localparam int DLY     = aarm_pkg::AXIS_LAT - ANG_LAT;
	localparam int TOT_LAT = aarm_pkg::AXIS_LAT + aarm_pkg::MAT_LAT;

	logic               en;
	logic [TOT_LAT-1:0] vld_q;

	logic signed [31:0] cos_a;
	logic signed [31:0] sin_a;
	logic signed [31:0] cos_dq [DLY];
	logic signed [31:0] sin_dq [DLY];

	logic signed [31:0] u_x;
	logic signed [31:0] u_y;
	logic signed [31:0] u_z;
	logic               zero_u;

	logic signed [31:0] m_out [9];

	// global advance: output register free or being taken
	assign en        = !vld_q[TOT_LAT-1] || out_ready;
	assign in_ready  = en;
	assign out_valid = vld_q[TOT_LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[TOT_LAT-2:0], in_valid};
		end
	end

	aarm_angle #(
		.CORDIC_STAGES(CORDIC_STAGES)
	) u_angle (
		.clk   (clk),
		.en    (en),
		.angle (angle),
		.cos_v (cos_a),
		.sin_v (sin_a)
	);

	// line up cosine and sine with the longer axis path
	always_ff @(posedge clk) begin
		if (en) begin
			cos_dq[0] <= cos_a;
			sin_dq[0] <= sin_a;
			for (int k = 1; k < DLY; k++) begin
				cos_dq[k] <= cos_dq[k-1];
				sin_dq[k] <= sin_dq[k-1];
			end
		end
	end

	aarm_axis u_axis (
		.clk    (clk),
		.en     (en),
		.axis_x (axis_x),
		.axis_y (axis_y),
		.axis_z (axis_z),
		.u_x    (u_x),
		.u_y    (u_y),
		.u_z    (u_z),
		.zero_v (zero_u)
	);

	aarm_matrix u_matrix (
		.clk      (clk),
		.en       (en),
		.u_x      (u_x),
		.u_y      (u_y),
		.u_z      (u_z),
		.cos_v    (cos_dq[DLY-1]),
		.sin_v    (sin_dq[DLY-1]),
		.zero_v   (zero_u),
		.m_out    (m_out),
		.zero_out (zero_axis)
	);

	assign entry_00 = m_out[0];
	assign entry_01 = m_out[1];
	assign entry_02 = m_out[2];
	assign entry_10 = m_out[3];
	assign entry_11 = m_out[4];
	assign entry_12 = m_out[5];
	assign entry_20 = m_out[6];
	assign entry_21 = m_out[7];
	assign entry_22 = m_out[8];

	// a zero axis must come out as an all-zero diagonal
	a_zero_matrix: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && zero_axis |-> entry_00 == '0 && entry_11 == '0 && entry_22 == '0)
		else $error("zero axis word with nonzero diagonal");

	// an empty output register never blocks the input
	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty output");

	// a stall freezes every stage's valid bit
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |=> $stable(vld_q))
		else $error("pipeline moved during stall");

endmodule

`default_nettype wire

// ----- dv/axis_angle_rotation_matrix_monitor.sv -----
// Channel monitor, matrix predictor and scoreboard for the rotation matrix block.
`timescale 1ns / 100ps

module axis_angle_rotation_matrix_monitor (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic signed [31:0] angle,
	input  logic signed [23:0] axis_x,
	input  logic signed [23:0] axis_y,
	input  logic signed [23:0] axis_z,
	input  logic               out_valid,
	input  logic               out_ready,
	input  logic signed [31:0] entry_00,
	input  logic signed [31:0] entry_01,
	input  logic signed [31:0] entry_02,
	input  logic signed [31:0] entry_10,
	input  logic signed [31:0] entry_11,
	input  logic signed [31:0] entry_12,
	input  logic signed [31:0] entry_20,
	input  logic signed [31:0] entry_21,
	input  logic signed [31:0] entry_22,
	input  logic               zero_axis,
	output int                 mismatches,
	output int                 matrices_pending
);

	localparam longint TWO_PI_Q27  = 64'sd843314857;
	localparam longint PI_Q27      = 64'sd421657428;
	localparam longint PI_Q30      = 64'sd3373259426;
	localparam longint HALF_PI_Q30 = 64'sd1686629713;
	localparam longint GAIN_Q30    = 64'sd652032874;
	localparam longint ONE_Q30     = 64'sd1073741824;

	typedef struct {
		logic signed [31:0] ent [9];
		logic               zflag;
	} rot_matrix_t;

	rot_matrix_t matrix_q [$];

	function automatic longint fx_mul(longint a, longint b);
		return (a * b + ONE_Q30 / 2) >>> 30;
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned v);
		longint unsigned res;
		longint unsigned bitv;
		res  = 0;
		bitv = 64'd1 << 62;
		while (bitv > v)
			bitv >>= 2;
		while (bitv != 0) begin
			if (v >= res + bitv) begin
				v   = v - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	function automatic logic signed [31:0] clamp32(longint v);
		if (v > 64'sd2147483647)
			return 32'sh7fffffff;
		if (v < -64'sd2147483648)
			return 32'sh80000000;
		return v[31:0];
	endfunction

	function automatic rot_matrix_t rodrigues(logic signed [31:0] ang,
		logic signed [23:0] ax, logic signed [23:0] ay, logic signed [23:0] az);
		rot_matrix_t m;
		longint a [3];
		longint u [3];
		longint unsigned ssq, nrm, rcp;
		longint r, x, y, z, dx, dy, c, s, t, sh;
		longint e [9];
		int sft;
		bit flip;
		a[0] = ax;
		a[1] = ay;
		a[2] = az;
		m.zflag = 1'b0;
		if (ax == 0 && ay == 0 && az == 0) begin
			foreach (m.ent[k])
				m.ent[k] = '0;
			m.zflag = 1'b1;
			return m;
		end
		// normalize: shift sum of squares up to 2^60, take inverse root
		ssq = a[0] * a[0] + a[1] * a[1] + a[2] * a[2];
		sft = 0;
		while ((ssq << sft) < (64'd1 << 60))
			sft += 2;
		nrm = int_sqrt(ssq << sft);
		rcp = (64'd1 << 62) / nrm;
		for (int k = 0; k < 3; k++) begin
			sh   = a[k] <<< (sft / 2);
			u[k] = (sh * longint'(rcp) + (64'sd1 <<< 31)) >>> 32;
		end
		// angle: reduce mod 2pi, fold into +-pi/2, CORDIC
		r = longint'(ang) % TWO_PI_Q27;
		if (r < 0)
			r += TWO_PI_Q27;
		if (r >= PI_Q27)
			r -= TWO_PI_Q27;
		z    = r * 8;
		flip = 1'b0;
		if (z > HALF_PI_Q30) begin
			z -= PI_Q30;
			flip = 1'b1;
		end else if (z < -HALF_PI_Q30) begin
			z += PI_Q30;
			flip = 1'b1;
		end
		x = GAIN_Q30;
		y = 0;
		for (int i = 0; i < aarm_pkg::CORDIC_STAGES_DEF && i < 32; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x -= dx;
				y += dy;
				z -= longint'(aarm_pkg::ATAN_Q30[i]);
			end else begin
				x += dx;
				y -= dy;
				z += longint'(aarm_pkg::ATAN_Q30[i]);
			end
		end
		c = flip ? -x : x;
		s = flip ? -y : y;
		t = ONE_Q30 - c;
		e[0] = c + fx_mul(fx_mul(u[0], u[0]), t);
		e[1] = fx_mul(fx_mul(u[0], u[1]), t) - fx_mul(u[2], s);
		e[2] = fx_mul(fx_mul(u[0], u[2]), t) + fx_mul(u[1], s);
		e[3] = fx_mul(fx_mul(u[1], u[0]), t) + fx_mul(u[2], s);
		e[4] = c + fx_mul(fx_mul(u[1], u[1]), t);
		e[5] = fx_mul(fx_mul(u[1], u[2]), t) - fx_mul(u[0], s);
		e[6] = fx_mul(fx_mul(u[2], u[0]), t) - fx_mul(u[1], s);
		e[7] = fx_mul(fx_mul(u[2], u[1]), t) + fx_mul(u[0], s);
		e[8] = c + fx_mul(fx_mul(u[2], u[2]), t);
		for (int k = 0; k < 9; k++)
			m.ent[k] = clamp32(e[k]);
		return m;
	endfunction

	task automatic report(string what, longint got, longint want);
		$display("mismatch at %0t: %s got %0d want %0d", $realtime, what, got, want);
		mismatches++;
	endtask

	initial begin
		mismatches       = 0;
		matrices_pending = 0;
	end

	always @(posedge clk) begin
		rot_matrix_t want;
		logic signed [31:0] seen [9];
		if (arst_n) begin
			if (in_valid && in_ready)
				matrix_q.push_back(rodrigues(angle, axis_x, axis_y, axis_z));
			if (out_valid && out_ready) begin
				seen = '{entry_00, entry_01, entry_02, entry_10, entry_11,
					entry_12, entry_20, entry_21, entry_22};
				if (matrix_q.size() == 0) begin
					report("unexpected word, zero_axis", zero_axis, 0);
				end else begin
					want = matrix_q.pop_front();
					for (int k = 0; k < 9; k++)
						if (seen[k] !== want.ent[k])
							report($sformatf("entry_%0d%0d", k / 3, k % 3),
								seen[k], want.ent[k]);
					if (zero_axis !== want.zflag)
						report("zero_axis", zero_axis, want.zflag);
				end
			end
			matrices_pending = matrix_q.size();
		end
	end

endmodule

// ----- dv/axis_angle_rotation_matrix_test.sv -----
// Top of the rotation matrix testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module axis_angle_rotation_matrix_test;

	localparam int RANDOM_WORDS = 1950;
	localparam int DRAIN_CYCLES = 100;   // pipeline is 74 deep
	localparam int CYCLE_LIMIT  = 400000;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic signed [31:0] angle;
	logic signed [23:0] axis_x;
	logic signed [23:0] axis_y;
	logic signed [23:0] axis_z;
	logic               out_valid;
	logic               out_ready;
	logic signed [31:0] entry_00, entry_01, entry_02;
	logic signed [31:0] entry_10, entry_11, entry_12;
	logic signed [31:0] entry_20, entry_21, entry_22;
	logic               zero_axis;
	int                 mismatches;
	int                 matrices_pending;

	// idle rates in percent, changed per phase
	int send_idle;
	int recv_idle;
	int cycles;

	axis_angle_rotation_matrix dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.angle(angle), .axis_x(axis_x), .axis_y(axis_y), .axis_z(axis_z),
		.out_valid(out_valid), .out_ready(out_ready),
		.entry_00(entry_00), .entry_01(entry_01), .entry_02(entry_02),
		.entry_10(entry_10), .entry_11(entry_11), .entry_12(entry_12),
		.entry_20(entry_20), .entry_21(entry_21), .entry_22(entry_22),
		.zero_axis(zero_axis)
	);

	axis_angle_rotation_matrix_monitor mon (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.angle(angle), .axis_x(axis_x), .axis_y(axis_y), .axis_z(axis_z),
		.out_valid(out_valid), .out_ready(out_ready),
		.entry_00(entry_00), .entry_01(entry_01), .entry_02(entry_02),
		.entry_10(entry_10), .entry_11(entry_11), .entry_12(entry_12),
		.entry_20(entry_20), .entry_21(entry_21), .entry_22(entry_22),
		.zero_axis(zero_axis),
		.mismatches(mismatches), .matrices_pending(matrices_pending)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// runaway guard
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// receiver: random backpressure, redrawn every falling edge
	always @(negedge clk)
		out_ready <= ($urandom_range(99) >= recv_idle);

	// One word: random idle gaps first, then hold valid until taken.
	task automatic send_word(logic signed [31:0] ang, logic signed [23:0] ax,
		logic signed [23:0] ay, logic signed [23:0] az);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		angle    <= ang;
		axis_x   <= ax;
		axis_y   <= ay;
		axis_z   <= az;
		do
			@(posedge clk);
		while (!in_ready);
		@(negedge clk);
	endtask

	// Axis component: often full-range, sometimes tiny, small or extreme.
	function automatic logic signed [23:0] pick_comp();
		unique case ($urandom_range(5))
			0: return 24'($urandom_range(7) - 3);
			1: return $urandom_range(1) ? 24'sh7fffff : 24'sh800000;
			2: return 24'($urandom_range(2000) - 1000);
			default: return 24'($urandom());
		endcase
	endfunction

	function automatic logic signed [31:0] pick_angle();
		unique case ($urandom_range(4))
			// near the half-pi fold boundary, both signs
			0: return ($urandom_range(1) ? 1 : -1) * (210828712 + $urandom_range(5));
			// near pi
			1: return ($urandom_range(1) ? 1 : -1) * (421657426 + $urandom_range(5));
			default: return $urandom();
		endcase
	endfunction

	initial begin
		logic signed [23:0] cx, cy, cz;
		cycles    = 0;
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		out_ready = 1'b0;
		angle     = '0;
		axis_x    = '0;
		axis_y    = '0;
		axis_z    = '0;
		send_idle = 29;
		recv_idle = 46;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: zero axis, axis and angle extremes, fold edges
		send_word(32'sd0, 24'sd0, 24'sd0, 24'sd0);
		send_word(32'sh7fffffff, 24'sd0, 24'sd0, 24'sd0);
		send_word(32'sh80000000, 24'sd0, 24'sd0, 24'sd0);
		send_word(32'sd0, 24'sd1, 24'sd0, 24'sd0);
		send_word(32'sh7fffffff, 24'sh7fffff, 24'sh7fffff, 24'sh7fffff);
		send_word(32'sh80000000, 24'sh800000, 24'sh800000, 24'sh800000);
		send_word(32'sd210828714, 24'sd0, 24'sd1, 24'sd0);
		send_word(32'sd210828715, 24'sd0, 24'sd0, 24'sd1);
		send_word(-32'sd210828714, 24'sh800000, 24'sd0, 24'sd0);
		send_word(-32'sd210828715, 24'sd0, 24'sh7fffff, 24'sd0);
		send_word(32'sd421657428, 24'sd3, 24'sd4, 24'sd0);
		send_word(32'sd421657427, 24'sd1, 24'sd1, 24'sd1);
		send_word(-32'sd421657428, -24'sd1, 24'sd2, -24'sd2);
		send_word(32'sd843314857, 24'sh7fffff, 24'sh800000, 24'sd1);
		send_word(-32'sd843314857, 24'sd0, 24'sd0, 24'sh800000);
		send_word(32'sd105414357, 24'sd1, 24'sd0, 24'sd0);
		send_word(32'sd134217728, 24'sh555555, 24'shaaaaaa, 24'sd0);
		send_word(32'sh55555555, 24'shaaaaaa, 24'sh555555, 24'sh7fffff);

		// random, in three idle phases; a full drain midway
		for (int n = 0; n < RANDOM_WORDS; n++) begin
			if (n == RANDOM_WORDS / 3) begin
				send_idle = 46;
				recv_idle = 29;
			end else if (n == 2 * RANDOM_WORDS / 3) begin
				send_idle = 0;
				recv_idle = 0;
			end
			if (n == RANDOM_WORDS / 2) begin
				in_valid <= 1'b0;
				do
					@(negedge clk);
				while (matrices_pending != 0);
			end
			cx = pick_comp();
			cy = pick_comp();
			cz = pick_comp();
			if ($urandom_range(49) == 0) begin
				cx = '0;
				cy = '0;
				cz = '0;
			end
			send_word(pick_angle(), cx, cy, cz);
		end
		in_valid <= 1'b0;

		while (matrices_pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// ----- files.f -----
rtl/aarm_pkg.sv
rtl/aarm_angle.sv
rtl/aarm_axis.sv
rtl/aarm_matrix.sv
rtl/axis_angle_rotation_matrix.sv
dv/axis_angle_rotation_matrix_monitor.sv
dv/axis_angle_rotation_matrix_test.sv
